// File: rtl/core/cbgd_pkg.sv
// ----------------------------------------------------------------------------
// cbgd_pkg - shared types and codes of the button gesture detector
// Pin status codes, key event and action codes, register indexes, register
// reset values and the structs passed between the top level and the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbgd_pkg;

    // Pin status carried by each poll
    typedef enum logic [1:0] {
        ST_HELD         = 2'd0,
        ST_RELEASED     = 2'd1,
        ST_PRESS_EDGE   = 2'd2,
        ST_RELEASE_EDGE = 2'd3
    } pin_status_t;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_SHORT        = 3'd1,
        EV_LONG         = 3'd2,
        EV_LONG_REL     = 3'd3,
        EV_DBL_LONG     = 3'd4,
        EV_DBL_LONG_REL = 3'd5
    } key_event_t;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_PAIR   = 3'd1,
        ACT_TOGGLE = 3'd2,
        ACT_LED    = 3'd3,
        ACT_RESET  = 3'd4
    } action_t;

    // Scenario codes
    localparam logic [1:0] SCN_OFF    = 2'd0;
    localparam logic [1:0] SCN_PAIR   = 2'd1;
    localparam logic [1:0] SCN_TOGGLE = 2'd2;

    // Register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_SCENARIO       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PIN_CONFIGURED = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DOUBLE_WINDOW  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_LOCAL_RST_DIS  = 3'd4;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned AWAKE_W    = 16;

    localparam logic [15:0] LONG_PRESS_RST    = 16'd3000;
    localparam logic [15:0] DOUBLE_WINDOW_RST = 16'd1000;

    typedef struct packed {
        logic [1:0]  scenario;
        logic        pin_configured;
        logic [15:0] long_press_ticks;
        logic [15:0] double_window_ticks;
        logic        local_reset_disable;
    } cfg_t;

    typedef struct packed {
        logic armed;
        logic last_was_long;
        logic double_check;
    } flags_t;

    typedef struct packed {
        key_event_t           key_event;
        action_t              action_code;
        logic [AWAKE_W-1:0]   stay_awake_ticks;
    } result_t;

endpackage

// File: rtl/core/cbgd_core.sv
// ----------------------------------------------------------------------------
// cbgd_core - gesture classification for one poll
// Combinational next state of the flags and countdown timer, the key event,
// its action code and the stay-awake request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbgd_core #(
    parameter int unsigned TIMER_BITS   = 16,
    parameter int unsigned AWAKE_MARGIN = 100
) (
    input  cbgd_pkg::pin_status_t   pin_status,
    input  cbgd_pkg::cfg_t          cfg,
    input  cbgd_pkg::flags_t        flags,
    input  logic [TIMER_BITS-1:0]   timer,
    output cbgd_pkg::flags_t        flags_next,
    output logic [TIMER_BITS-1:0]   timer_next,
    output cbgd_pkg::result_t       result
);

    localparam logic [32:0] TMAX   = (33'd1 << TIMER_BITS) - 33'd1;
    localparam logic [16:0] MARGIN = 17'(AWAKE_MARGIN);

    logic [TIMER_BITS-1:0]          t_dec;
    logic [TIMER_BITS-1:0]          long_sat;
    logic [TIMER_BITS-1:0]          dbl_sat;
    logic [16:0]                    long_sum;
    logic [16:0]                    dbl_sum;
    logic [cbgd_pkg::AWAKE_W-1:0]   long_awake;
    logic [cbgd_pkg::AWAKE_W-1:0]   dbl_awake;
    logic [cbgd_pkg::AWAKE_W-1:0]   awake;
    logic                           active;
    cbgd_pkg::key_event_t           ev;
    cbgd_pkg::action_t              act;

    // Clamp a load to the timer width
    assign long_sat = (33'(cfg.long_press_ticks) > TMAX) ? TMAX[TIMER_BITS-1:0]
                                                         : TIMER_BITS'(cfg.long_press_ticks);
    assign dbl_sat  = (33'(cfg.double_window_ticks) > TMAX) ? TMAX[TIMER_BITS-1:0]
                                                            : TIMER_BITS'(cfg.double_window_ticks);

    // Wake request: load plus margin, held at all ones on overflow
    assign long_sum   = {1'b0, cfg.long_press_ticks} + MARGIN;
    assign dbl_sum    = {1'b0, cfg.double_window_ticks} + MARGIN;
    assign long_awake = long_sum[16] ? '1 : long_sum[15:0];
    assign dbl_awake  = dbl_sum[16]  ? '1 : dbl_sum[15:0];

    assign active = (cfg.scenario != cbgd_pkg::SCN_OFF) && cfg.pin_configured;
    assign t_dec  = (timer != '0) ? timer - TIMER_BITS'(1) : timer;

    always_comb begin
        timer_next = t_dec;
        flags_next = flags;
        ev         = cbgd_pkg::EV_NONE;
        awake      = '0;
        if (active) begin
            if (pin_status == cbgd_pkg::ST_PRESS_EDGE) begin
                timer_next       = long_sat;
                awake            = long_awake;
                flags_next.armed = 1'b1;
            end
            if (flags_next.armed) begin
                if (pin_status == cbgd_pkg::ST_RELEASE_EDGE) begin
                    timer_next = dbl_sat;
                    awake      = dbl_awake;
                    if (flags.last_was_long && !flags.double_check) begin
                        flags_next.double_check  = 1'b1;
                        flags_next.last_was_long = 1'b0;
                        ev                       = cbgd_pkg::EV_LONG_REL;
                    end else if (flags.last_was_long) begin
                        ev = cbgd_pkg::EV_DBL_LONG_REL;
                    end else begin
                        ev = cbgd_pkg::EV_SHORT;
                    end
                end
                if (timer_next == '0) begin
                    case (pin_status)
                        cbgd_pkg::ST_HELD: begin
                            timer_next = long_sat;
                            awake      = long_awake;
                            if (!flags_next.last_was_long) begin
                                flags_next.last_was_long = 1'b1;
                                ev = flags_next.double_check ? cbgd_pkg::EV_DBL_LONG
                                                             : cbgd_pkg::EV_LONG;
                            end
                        end
                        cbgd_pkg::ST_RELEASED: begin
                            flags_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_comb begin
        case (ev)
            cbgd_pkg::EV_SHORT: begin
                if (cfg.scenario == cbgd_pkg::SCN_PAIR) begin
                    act = cbgd_pkg::ACT_PAIR;
                end else if (cfg.scenario == cbgd_pkg::SCN_TOGGLE) begin
                    act = cbgd_pkg::ACT_TOGGLE;
                end else begin
                    act = cbgd_pkg::ACT_NONE;
                end
            end
            cbgd_pkg::EV_LONG, cbgd_pkg::EV_DBL_LONG: begin
                act = cbgd_pkg::ACT_LED;
            end
            cbgd_pkg::EV_LONG_REL: begin
                act = (cfg.scenario == cbgd_pkg::SCN_TOGGLE)
                      ? cbgd_pkg::ACT_PAIR : cbgd_pkg::ACT_NONE;
            end
            cbgd_pkg::EV_DBL_LONG_REL: begin
                act = cfg.local_reset_disable
                      ? cbgd_pkg::ACT_NONE : cbgd_pkg::ACT_RESET;
            end
            default: begin
                act = cbgd_pkg::ACT_NONE;
            end
        endcase
    end

    assign result = {ev, act, awake};

endmodule

// File: rtl/core/config_button_gesture_detector.sv
// ----------------------------------------------------------------------------
// config_button_gesture_detector - button gesture detector top level
// One poll request a millisecond tick carries the pin status (held, released,
// press edge, release edge); each poll gives exactly one result request with
// the key event (short, long, long release, double long, double long
// release), the action that the scenario register maps it to, and a
// stay-awake time whenever the countdown timer is loaded. A poll is taken in every
// cycle that the result register is empty or being drained: the whole classification
// is one pass of logic between the state registers and the result register, so an
// accepted poll appears on the result port in the next cycle. Throughput is one poll
// per cycle while m_ready is high; the output register drains as the next poll is taken.
// Registers are written through cfg_wr_en / cfg_addr / cfg_wdata, with no
// wait and no read-back; indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module config_button_gesture_detector #(
    parameter int unsigned TIMER_BITS   = 16,
    parameter int unsigned AWAKE_MARGIN = 100
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [cbgd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [cbgd_pkg::CFG_DATA_W-1:0]     cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_pin_status,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [2:0]                          m_key_event,
    output logic [2:0]                          m_action_code,
    output logic [15:0]                         m_stay_awake_ticks
);

    cbgd_pkg::cfg_t             cfg_reg, cfg_next;
    cbgd_pkg::flags_t           flags_reg, flags_next;
    logic [TIMER_BITS-1:0]      timer_reg, timer_next;
    logic                       m_valid_reg, m_valid_next;
    cbgd_pkg::result_t          result_reg, result_next;
    logic                       accept;

    // ------------------------------------------------------------------
    // Configuration registers: take a write whenever the enable is high
    // ------------------------------------------------------------------
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                cbgd_pkg::REG_SCENARIO:       cfg_next.scenario       = cfg_wdata[1:0];
                cbgd_pkg::REG_PIN_CONFIGURED: cfg_next.pin_configured = cfg_wdata[0];
                cbgd_pkg::REG_LONG_PRESS:     cfg_next.long_press_ticks = cfg_wdata;
                cbgd_pkg::REG_DOUBLE_WINDOW:  cfg_next.double_window_ticks = cfg_wdata;
                cbgd_pkg::REG_LOCAL_RST_DIS:  cfg_next.local_reset_disable = cfg_wdata[0];
                default: begin
                    // Drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scenario            <= cbgd_pkg::SCN_OFF;
            cfg_reg.pin_configured      <= 1'b0;
            cfg_reg.long_press_ticks    <= cbgd_pkg::LONG_PRESS_RST;
            cfg_reg.double_window_ticks <= cbgd_pkg::DOUBLE_WINDOW_RST;
            cfg_reg.local_reset_disable <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Poll handshake: accept while the result register is empty or being
    // drained in the same cycle
    // ------------------------------------------------------------------
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    cbgd_core #(
        .TIMER_BITS   (TIMER_BITS),
        .AWAKE_MARGIN (AWAKE_MARGIN)
    ) u_core (
        .pin_status (cbgd_pkg::pin_status_t'(s_pin_status)),
        .cfg        (cfg_reg),
        .flags      (flags_reg),
        .timer      (timer_reg),
        .flags_next (flags_next),
        .timer_next (timer_next),
        .result     (result_next)
    );

    // Advance the gesture state only on an accepted poll
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
            timer_reg <= '0;
        end else if (accept) begin
            flags_reg <= flags_next;
            timer_reg <= timer_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on accept, hold while stalled
    // ------------------------------------------------------------------
    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_key_event        = result_reg.key_event;
    assign m_action_code      = result_reg.action_code;
    assign m_stay_awake_ticks = result_reg.stay_awake_ticks;

`ifndef SYNTH
    // Repeat flags only live while the block is armed
    a_flags_need_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        !flags_reg.armed |-> (!flags_reg.last_was_long && !flags_reg.double_check))
        else $error("repeat flag set while disarmed");

    // No event never carries an action
    a_no_event_no_action: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_key_event == cbgd_pkg::EV_NONE))
            |-> (m_action_code == cbgd_pkg::ACT_NONE))
        else $error("action without key event");

    // An idle block reports all-zero results
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ((cfg_reg.scenario == cbgd_pkg::SCN_OFF) || !cfg_reg.pin_configured))
            |=> (m_valid && (m_key_event == cbgd_pkg::EV_NONE)
                 && (m_stay_awake_ticks == '0)))
        else $error("idle poll produced a result");

    // A stalled result blocks the next poll
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("poll taken over a stalled result");
`endif

endmodule

// File: bench/tb_config_button_gesture_detector.sv
// ----------------------------------------------------------------------------
// tb_config_button_gesture_detector - regression bench for the gesture detector
// Drives poll requests made of whole button gestures (press, hold, release,
// rest) and random noise under a series of register settings. A predictor of
// the flags and the countdown works out the expected key event, action and
// stay-awake request of every accepted poll. Each result request is checked
// against the oldest expectation, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Tracks the detector state and holds the results still awaited
class gesture_ledger;
    logic [1:0]          scenario;
    logic                pin_configured;
    logic [15:0]         long_ticks;
    logic [15:0]         window_ticks;
    logic                reset_disable;
    bit                  armed;
    bit                  long_flag;
    bit                  double_seen;
    longint unsigned     countdown;
    longint unsigned     countdown_max;
    int unsigned         margin;
    logic [15:0]         wake_req;
    cbgd_pkg::result_t   awaited_results[$];
    int                  failures;

    function new(int unsigned timer_bits, int unsigned awake_margin);
        countdown_max  = (64'd1 << timer_bits) - 1;
        margin         = awake_margin;
        scenario       = cbgd_pkg::SCN_OFF;
        pin_configured = 1'b0;
        long_ticks     = cbgd_pkg::LONG_PRESS_RST;
        window_ticks   = cbgd_pkg::DOUBLE_WINDOW_RST;
        reset_disable  = 1'b0;
        armed          = 1'b0;
        long_flag      = 1'b0;
        double_seen    = 1'b0;
        countdown      = 0;
        wake_req       = '0;
        failures       = 0;
    endfunction

    function void write_reg(logic [cbgd_pkg::CFG_ADDR_W-1:0] idx,
                            logic [cbgd_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            cbgd_pkg::REG_SCENARIO:       scenario       = val[1:0];
            cbgd_pkg::REG_PIN_CONFIGURED: pin_configured = val[0];
            cbgd_pkg::REG_LONG_PRESS:     long_ticks     = val[15:0];
            cbgd_pkg::REG_DOUBLE_WINDOW:  window_ticks   = val[15:0];
            cbgd_pkg::REG_LOCAL_RST_DIS:  reset_disable  = val[0];
            default: ;
        endcase
    endfunction

    // Reload the countdown and raise the stay-awake request, saturated
    function void load_countdown(logic [15:0] ticks);
        longint unsigned sum;
        countdown = (ticks > countdown_max) ? countdown_max : ticks;
        sum       = ticks + margin;
        wake_req  = (sum > 64'hFFFF) ? 16'hFFFF : sum[15:0];
    endfunction

    function cbgd_pkg::action_t action_for(cbgd_pkg::key_event_t ev);
        case (ev)
            cbgd_pkg::EV_SHORT: begin
                if (scenario == cbgd_pkg::SCN_PAIR)
                    return cbgd_pkg::ACT_PAIR;
                if (scenario == cbgd_pkg::SCN_TOGGLE)
                    return cbgd_pkg::ACT_TOGGLE;
                return cbgd_pkg::ACT_NONE;
            end
            cbgd_pkg::EV_LONG, cbgd_pkg::EV_DBL_LONG:
                return cbgd_pkg::ACT_LED;
            cbgd_pkg::EV_LONG_REL:
                return (scenario == cbgd_pkg::SCN_TOGGLE) ? cbgd_pkg::ACT_PAIR
                                                          : cbgd_pkg::ACT_NONE;
            cbgd_pkg::EV_DBL_LONG_REL:
                return reset_disable ? cbgd_pkg::ACT_NONE : cbgd_pkg::ACT_RESET;
            default:
                return cbgd_pkg::ACT_NONE;
        endcase
    endfunction

    function void note_poll(cbgd_pkg::pin_status_t st);
        cbgd_pkg::result_t    r;
        cbgd_pkg::key_event_t ev;
        ev       = cbgd_pkg::EV_NONE;
        wake_req = '0;
        // the countdown runs on every poll, idle or not
        if (countdown != 0)
            countdown--;
        if (scenario != cbgd_pkg::SCN_OFF && pin_configured) begin
            if (st == cbgd_pkg::ST_PRESS_EDGE) begin
                load_countdown(long_ticks);
                armed = 1'b1;
            end
            if (armed) begin
                if (st == cbgd_pkg::ST_RELEASE_EDGE) begin
                    load_countdown(window_ticks);
                    if (long_flag && !double_seen) begin
                        double_seen = 1'b1;
                        long_flag   = 1'b0;
                        ev          = cbgd_pkg::EV_LONG_REL;
                    end else if (long_flag) begin
                        ev = cbgd_pkg::EV_DBL_LONG_REL;
                    end else begin
                        ev = cbgd_pkg::EV_SHORT;
                    end
                end
                if (countdown == 0) begin
                    if (st == cbgd_pkg::ST_HELD) begin
                        load_countdown(long_ticks);
                        if (!long_flag) begin
                            long_flag = 1'b1;
                            ev        = double_seen ? cbgd_pkg::EV_DBL_LONG
                                                    : cbgd_pkg::EV_LONG;
                        end
                    end else if (st == cbgd_pkg::ST_RELEASED) begin
                        armed       = 1'b0;
                        long_flag   = 1'b0;
                        double_seen = 1'b0;
                    end
                end
            end
        end
        r.key_event        = ev;
        r.action_code      = action_for(ev);
        r.stay_awake_ticks = wake_req;
        awaited_results.push_back(r);
    endfunction

    function void check_result(logic [2:0] ev, logic [2:0] act, logic [15:0] awake);
        cbgd_pkg::result_t want;
        if (awaited_results.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("%0t: unexpected result event=%0d action=%0d awake=%0d",
                         $time, ev, act, awake);
            return;
        end
        want = awaited_results.pop_front();
        if (want.key_event !== ev || want.action_code !== act ||
            want.stay_awake_ticks !== awake) begin
            failures++;
            if (failures <= 10)
                $display("%0t: mismatch event %0d/%0d action %0d/%0d awake %0d/%0d (exp/act)",
                         $time, want.key_event, ev, want.action_code, act,
                         want.stay_awake_ticks, awake);
        end
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction
endclass

module tb_config_button_gesture_detector;

    localparam int unsigned TIMER_BITS   = 16;
    localparam int unsigned AWAKE_MARGIN = 100;
    localparam int          PHASES       = 10;
    localparam int          PHASE_POLLS  = 105;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_wr_en = 1'b0;
    logic [cbgd_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
    logic [cbgd_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [1:0]                       s_pin_status = cbgd_pkg::ST_RELEASED;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [2:0]                       m_key_event;
    logic [2:0]                       m_action_code;
    logic [15:0]                      m_stay_awake_ticks;

    gesture_ledger          ledger;
    int unsigned            cycle_count = 0;
    int                     stall_left = 0;
    int                     polls_sent = 0;
    // hold and rest lengths of random gestures follow these copies of the
    // current long-press and double-window settings
    logic [15:0]            cur_long = cbgd_pkg::LONG_PRESS_RST;
    logic [15:0]            cur_window = cbgd_pkg::DOUBLE_WINDOW_RST;

    config_button_gesture_detector #(
        .TIMER_BITS         (TIMER_BITS),
        .AWAKE_MARGIN       (AWAKE_MARGIN)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_pin_status       (s_pin_status),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_key_event        (m_key_event),
        .m_action_code      (m_action_code),
        .m_stay_awake_ticks (m_stay_awake_ticks)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // One stretch in four runs with no idling on either side
    function automatic bit calm_stretch();
        return cycle_count[9:8] == 2'b11;
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm_stretch())
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: check each accepted result request, then decide on stalls.
    // Values read here are those from before the edge, as the block sees them.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            ledger.check_result(m_key_event, m_action_code, m_stay_awake_ticks);
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready    <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // Called just after the clock rises. Hold valid and the status until the
    // request is taken; when no gap is drawn, valid stays high into the next
    // request without being lowered.
    task automatic send_poll(cbgd_pkg::pin_status_t st);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pin_status <= st;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ledger.note_poll(st);
        polls_sent++;
    endtask

    // Drop valid and wait until every awaited result has come back, then let
    // the output register settle
    task automatic drain();
        s_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write all five registers, one per cycle, then drop the write enable
    task automatic configure(logic [1:0] scn, logic pin, logic [15:0] lp,
                             logic [15:0] dw, logic dis);
        logic [cbgd_pkg::CFG_ADDR_W-1:0] idx [5];
        logic [cbgd_pkg::CFG_DATA_W-1:0] val [5];
        idx[0] = cbgd_pkg::REG_SCENARIO;       val[0] = {14'd0, scn};
        idx[1] = cbgd_pkg::REG_PIN_CONFIGURED; val[1] = {15'd0, pin};
        idx[2] = cbgd_pkg::REG_LONG_PRESS;     val[2] = lp;
        idx[3] = cbgd_pkg::REG_DOUBLE_WINDOW;  val[3] = dw;
        idx[4] = cbgd_pkg::REG_LOCAL_RST_DIS;  val[4] = {15'd0, dis};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
            ledger.write_reg(idx[i], val[i]);
        end
        cfg_wr_en  <= 1'b0;
        cur_long   = lp;
        cur_window = dw;
    endtask

    // Mostly whole gestures with random hold and rest lengths around the
    // current thresholds, so long, double-long and timeout paths are reached;
    // the rest is random status noise that breaks sequences up
    task automatic run_gestures(int n);
        int first, hold, rest, lim_l, lim_w;
        first = polls_sent;
        lim_l = (cur_long > 10) ? 10 : int'(cur_long);
        lim_w = (cur_window > 10) ? 10 : int'(cur_window);
        while (polls_sent - first < n) begin
            if ($urandom_range(0, 9) < 7) begin
                send_poll(cbgd_pkg::ST_PRESS_EDGE);
                hold = $urandom_range(0, 2 * lim_l + 2);
                repeat (hold) send_poll(cbgd_pkg::ST_HELD);
                send_poll(cbgd_pkg::ST_RELEASE_EDGE);
                rest = $urandom_range(0, lim_w + 2);
                repeat (rest) send_poll(cbgd_pkg::ST_RELEASED);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_poll(cbgd_pkg::pin_status_t'($urandom_range(0, 3)));
            end
        end
    endtask

    initial begin
        #5_000_000;
        $display("config_button_gesture_detector regression: fail");
        $finish;
    end

    initial begin
        logic [1:0]  scn;
        logic        pin;
        logic [15:0] lp;
        logic [15:0] dw;
        logic        dis;

        ledger = new(TIMER_BITS, AWAKE_MARGIN);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Out of reset the block is off: every status gives an all-zero result
        send_poll(cbgd_pkg::ST_HELD);
        send_poll(cbgd_pkg::ST_RELEASED);
        send_poll(cbgd_pkg::ST_PRESS_EDGE);
        send_poll(cbgd_pkg::ST_RELEASE_EDGE);
        drain();

        // A scenario alone is not enough while the pin is not configured
        configure(cbgd_pkg::SCN_PAIR, 1'b0, cbgd_pkg::LONG_PRESS_RST,
                  cbgd_pkg::DOUBLE_WINDOW_RST, 1'b0);
        send_poll(cbgd_pkg::ST_PRESS_EDGE);
        send_poll(cbgd_pkg::ST_RELEASE_EDGE);
        drain();

        configure(cbgd_pkg::SCN_PAIR, 1'b1, 16'd2, 16'd3, 1'b0);
        // short press, then rest until the window runs out and disarms
        send_poll(cbgd_pkg::ST_PRESS_EDGE);
        send_poll(cbgd_pkg::ST_RELEASE_EDGE);
        repeat (3) send_poll(cbgd_pkg::ST_RELEASED);
        // long press, long release, double-long press, double-long release
        send_poll(cbgd_pkg::ST_PRESS_EDGE);
        repeat (3) send_poll(cbgd_pkg::ST_HELD);
        send_poll(cbgd_pkg::ST_RELEASE_EDGE);
        send_poll(cbgd_pkg::ST_PRESS_EDGE);
        repeat (2) send_poll(cbgd_pkg::ST_HELD);
        send_poll(cbgd_pkg::ST_RELEASE_EDGE);
        repeat (3) send_poll(cbgd_pkg::ST_RELEASED);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin  // smallest thresholds, toggle scenario, reset disabled
                    scn = cbgd_pkg::SCN_TOGGLE; pin = 1'b1; lp = 16'd1; dw = 16'd1;
                    dis = 1'b1;
                end
                1: begin  // the unused scenario code
                    scn = 2'd3; pin = 1'b1; lp = 16'd3; dw = 16'd4; dis = 1'b0;
                end
                2: begin  // largest thresholds: stay-awake request saturates
                    scn = cbgd_pkg::SCN_PAIR; pin = 1'b1; lp = 16'hFFFF; dw = 16'hFFFF;
                    dis = 1'b0;
                end
                3: begin  // scenario off
                    scn = cbgd_pkg::SCN_OFF; pin = 1'b1; lp = 16'd2; dw = 16'd2;
                    dis = 1'b0;
                end
                4: begin  // pin not configured
                    scn = cbgd_pkg::SCN_TOGGLE; pin = 1'b0; lp = 16'd2; dw = 16'd2;
                    dis = 1'b1;
                end
                5: begin  // just below saturation of the request
                    scn = cbgd_pkg::SCN_TOGGLE; pin = 1'b1; lp = 16'd1; dw = 16'd65435;
                    dis = 1'b0;
                end
                default: begin
                    scn = 2'($urandom_range(1, 3));
                    pin = ($urandom_range(0, 9) != 0);
                    lp  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                                      : 16'($urandom_range(1, 8));
                    dw  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                                      : 16'($urandom_range(1, 8));
                    dis = 1'($urandom_range(0, 1));
                end
            endcase
            configure(scn, pin, lp, dw, dis);
            run_gestures(PHASE_POLLS);
            drain();
        end

        repeat (10) @(posedge aclk);
        if (ledger.failures == 0 && ledger.pending() == 0)
            $display("config_button_gesture_detector regression: pass");
        else
            $display("config_button_gesture_detector regression: fail");
        $finish;
    end

endmodule
